// ===== rtl/lsn_pkg.sv =====
// ----------------------------------------------------------------------------
// lsn_pkg: shared types and constants
// fixed sizes, request codes, register indexes, payload structs
// ----------------------------------------------------------------------------
`default_nettype none

package lsn_pkg;

    localparam int IN_SIZE  = 64;
    localparam int HID_SIZE = 32;
    localparam int OUT_SIZE = 16;

    localparam logic [1:0] REQ_WEIGHT = 2'd0;
    localparam logic [1:0] REQ_INPUT  = 2'd1;
    localparam logic [1:0] REQ_RESET  = 2'd2;

    localparam logic [1:0] CFG_DECAY  = 2'd0;
    localparam logic [1:0] CFG_THRESH = 2'd1;
    localparam logic [1:0] CFG_RESET  = 2'd2;

    localparam logic signed [23:0] P_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] P_MIN = -24'sh800000;

    typedef struct packed {
        logic [1:0]         req_type;
        logic               weight_layer;
        logic [5:0]         src_index;
        logic [4:0]         dst_index;
        logic signed [15:0] value;
        logic               last_input;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  predicted_class;
        logic [15:0] max_spike_count;
        logic [15:0] output_spikes;
    } t_out_beat;

    typedef struct packed {
        logic [15:0]        decay;
        logic signed [23:0] thresh;
        logic signed [23:0] rst_lvl;
    } t_cfg;

    // saturate a 26-bit signed sum to 24 bits
    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        if (v > 26'(P_MAX)) return P_MAX;
        if (v < 26'(P_MIN)) return P_MIN;
        return v[23:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lsn_neuron.sv =====
// ----------------------------------------------------------------------------
// lsn_neuron: two-stage leak, integrate and fire datapath
// stage one registers the decay product, stage two rounds, adds and compares
// ----------------------------------------------------------------------------
`default_nettype none

module lsn_neuron
    import lsn_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_cfg               i_cfg,
    input  wire logic signed [23:0] i_pot,
    input  wire logic signed [23:0] i_cur,
    output logic signed [23:0]      o_pot,
    output logic                    o_spike
);

    logic signed [40:0] r_prod;
    logic signed [23:0] r_cur;
    logic signed [25:0] leaked;
    logic signed [23:0] sum;

    always_ff @(posedge i_clk) begin
        r_prod <= i_pot * $signed({1'b0, i_cfg.decay});
        r_cur  <= i_cur;
    end

    always_comb begin
        leaked  = 26'((r_prod + 41'sd16384) >>> 15);
        sum     = sat24(leaked + 26'(r_cur));
        o_spike = (sum >= i_cfg.thresh);
        o_pot   = o_spike ? i_cfg.rst_lvl : sum;
    end

endmodule

`default_nettype wire

// ===== rtl/lif_spiking_network_step.sv =====
// ----------------------------------------------------------------------------
// lif_spiking_network_step: three-layer leaky integrate-and-fire network
// memory-based sequencer over potentials and weight rows, one weight per cycle
// ----------------------------------------------------------------------------
// usage
//   input channel i_in_valid / o_in_stall carries one request beat; the block
//   stalls while a request is at work, so one beat is taken at a time
//   weight write and unused request type: done in idle, beats can follow directly
//   reset request: clearing pass over the 128-entry potential memory, with
//   hidden sums and spike counts swept along
//   input current: read, update and write-back of the input potential, plus a
//   row sweep when it spikes (one weight read per cycle from the weight memory)
//   last input: read, update and write-back of each hidden neuron, with a sweep
//   of its 16-weight row for each spiking hidden neuron, then output neuron
//   updates, an argmax scan over the spike counts and loading of the result
//   the result beat is held in an output register on o_out_valid until
//   i_out_stall drops; input reopens once the beat is loaded, and a later
//   result waits in the last state while the register is still full
//   after reset all potentials and counts read zero: the clearing pass runs
//   first (input stalled), configuration writes are taken anytime
// ----------------------------------------------------------------------------
`default_nettype none

module lif_spiking_network_step
    import lsn_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_beat    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_beat        o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_IN_RD = 4'd2;
    localparam logic [3:0] S_IN_NU = 4'd3;
    localparam logic [3:0] S_IN_WB = 4'd4;
    localparam logic [3:0] S_ROW   = 4'd5;
    localparam logic [3:0] S_H_RD  = 4'd6;
    localparam logic [3:0] S_H_NU  = 4'd7;
    localparam logic [3:0] S_H_WB  = 4'd8;
    localparam logic [3:0] S_HROW  = 4'd9;
    localparam logic [3:0] S_O_RD  = 4'd10;
    localparam logic [3:0] S_O_NU  = 4'd11;
    localparam logic [3:0] S_O_WB  = 4'd12;
    localparam logic [3:0] S_ARG   = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    // config registers
    t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay   <= 16'd29491;
            r_cfg.thresh  <= 24'sd256;
            r_cfg.rst_lvl <= 24'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DECAY:  r_cfg.decay   <= i_cfg_data[15:0];
                CFG_THRESH: r_cfg.thresh  <= i_cfg_data;
                CFG_RESET:  r_cfg.rst_lvl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // memories: potentials of all layers share one array at disjoint ranges
    // (input 0..63, hidden 64..95, output 96..111), hidden sums and counts apart
    logic [23:0] m_pot [0:127];
    logic [23:0] m_hsum [0:31];
    logic [15:0] m_cnt [0:15];
    logic [15:0] m_wih [0:2047];
    logic [15:0] m_who [0:511];

    logic [3:0]  r_state;
    logic [5:0]  r_idx;       // neuron under work
    logic [5:0]  r_cnt;       // sweep counter
    logic        r_last;
    logic [15:0] r_mask;
    logic signed [23:0] r_osum [0:15];
    logic [3:0]  r_best_idx;
    logic [15:0] r_best;
    logic        r_ovalid;
    t_out_beat   r_odata;
    logic signed [23:0] r_in_val;
    logic               r_clr_hi;
    logic               accept;

    // memory ports
    logic [6:0]  pot_ra, pot_wa;
    logic        pot_we;
    logic [23:0] pot_wd, r_pot_rd;
    logic [4:0]  hs_ra, hs_wa;
    logic        hs_we;
    logic [23:0] hs_wd, r_hs_rd;
    logic [3:0]  cnt_ra, cnt_wa;
    logic        cnt_we;
    logic [15:0] cnt_wd, r_cnt_rd;
    logic [10:0] wih_ra;
    logic [15:0] r_wih_rd;
    logic [8:0]  who_ra;
    logic [15:0] r_who_rd;

    always_ff @(posedge i_clk) begin
        if (pot_we) m_pot[pot_wa] <= pot_wd;
        r_pot_rd <= m_pot[pot_ra];
        if (hs_we) m_hsum[hs_wa] <= hs_wd;
        r_hs_rd <= m_hsum[hs_ra];
        if (cnt_we) m_cnt[cnt_wa] <= cnt_wd;
        r_cnt_rd <= m_cnt[cnt_ra];
        if (accept && i_in_data.req_type == REQ_WEIGHT && !i_in_data.weight_layer)
            m_wih[{i_in_data.src_index, i_in_data.dst_index}] <= i_in_data.value;
        if (accept && i_in_data.req_type == REQ_WEIGHT && i_in_data.weight_layer
            && !i_in_data.src_index[5] && !i_in_data.dst_index[4])
            m_who[{i_in_data.src_index[4:0], i_in_data.dst_index[3:0]}] <= i_in_data.value;
        r_wih_rd <= m_wih[wih_ra];
        r_who_rd <= m_who[who_ra];
    end

    // neuron datapath
    logic signed [23:0] nu_cur, nu_pot;
    logic               nu_spike;
    lsn_neuron u_neuron (
        .i_clk   (i_clk),
        .i_cfg   (r_cfg),
        .i_pot   (r_pot_rd),
        .i_cur   (nu_cur),
        .o_pot   (nu_pot),
        .o_spike (nu_spike)
    );

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // row sweep pipeline: address issued at r_cnt, data back in the next cycle
    logic       r_row_v;
    logic [4:0] r_row_j;
    logic       r_spk;
    logic [3:0] osel;
    assign osel = r_cnt[3:0] - 4'd1;

    always_comb begin
        pot_ra = {1'b0, r_idx};
        pot_wa = {1'b0, r_idx};
        pot_we = 1'b0;
        pot_wd = nu_pot;
        hs_ra  = r_idx[4:0];
        hs_wa  = r_row_j;
        hs_we  = 1'b0;
        hs_wd  = sat24(26'($signed(r_hs_rd)) + 26'($signed(r_wih_rd)));
        cnt_ra = r_cnt[3:0];
        cnt_wa = r_idx[3:0];
        cnt_we = 1'b0;
        cnt_wd = (r_cnt_rd == 16'hFFFF) ? r_cnt_rd : r_cnt_rd + 16'd1;
        wih_ra = {r_idx, r_cnt[4:0]};
        who_ra = {r_idx[4:0], r_cnt[3:0]};
        nu_cur = r_in_val;
        unique case (r_state)
            S_CLR: begin
                // lower half of the potential memory first, then the upper half
                pot_we = 1'b1; pot_wa = {r_clr_hi, r_cnt}; pot_wd = '0;
                hs_we = 1'b1; hs_wa = r_cnt[4:0]; hs_wd = '0;
                cnt_we = 1'b1; cnt_wa = r_cnt[3:0]; cnt_wd = '0;
            end
            S_IN_WB: pot_we = 1'b1;
            S_ROW: begin
                hs_ra = r_cnt[4:0];
                hs_we = r_row_v;
            end
            S_H_RD, S_H_NU: begin
                pot_ra = {2'b10, r_idx[4:0]};
                hs_ra = r_idx[4:0];
            end
            S_H_WB: begin
                pot_we = 1'b1; pot_wa = {2'b10, r_idx[4:0]};
                hs_we = 1'b1; hs_wa = r_idx[4:0]; hs_wd = '0;
            end
            S_O_RD, S_O_NU: begin
                pot_ra = {3'b110, r_idx[3:0]};
                cnt_ra = r_idx[3:0];
            end
            S_O_WB: begin
                pot_we = 1'b1; pot_wa = {3'b110, r_idx[3:0]};
                cnt_we = nu_spike;
            end
            default: ;
        endcase
        if (r_state == S_H_NU) nu_cur = r_hs_rd;
        if (r_state == S_O_NU) nu_cur = r_osum[r_idx[3:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_row_v  <= 1'b0;
            r_clr_hi <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            r_row_v <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    // potentials 0..63 then 64..127 share the sweep via r_clr_hi
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        if (r_clr_hi) begin
                            r_state <= S_IDLE;
                        end
                        r_clr_hi <= !r_clr_hi;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_idx    <= i_in_data.src_index;
                        r_in_val <= 24'(i_in_data.value);
                        r_last   <= i_in_data.last_input;
                        r_cnt    <= '0;
                        if (i_in_data.req_type == REQ_RESET) r_state <= S_CLR;
                        else if (i_in_data.req_type == REQ_INPUT) r_state <= S_IN_RD;
                    end
                end
                S_IN_RD: r_state <= S_IN_NU;
                S_IN_NU: r_state <= S_IN_WB;
                S_IN_WB: begin
                    r_cnt <= '0;
                    if (nu_spike) r_state <= S_ROW;
                    else if (r_last) begin
                        r_state <= S_H_RD; r_idx <= '0;
                    end else r_state <= S_IDLE;
                end
                S_ROW: begin
                    r_row_v <= !r_cnt[5];
                    r_row_j <= r_cnt[4:0];
                    r_cnt   <= r_cnt + 6'd1;
                    if (r_cnt[5]) begin
                        if (r_last) begin
                            r_state <= S_H_RD; r_idx <= '0;
                        end else r_state <= S_IDLE;
                    end
                end
                S_H_RD: begin
                    if (r_idx == 6'd0) begin
                        for (int k = 0; k < OUT_SIZE; k++) r_osum[k] <= '0;
                        r_mask <= '0;
                    end
                    r_state <= S_H_NU;
                end
                S_H_NU: r_state <= S_H_WB;
                S_H_WB: begin
                    r_cnt <= '0;
                    if (nu_spike) r_state <= S_HROW;
                    else if (r_idx[4:0] == 5'd31) begin
                        r_state <= S_O_RD; r_idx <= '0;
                    end else begin
                        r_state <= S_H_RD; r_idx <= r_idx + 6'd1;
                    end
                end
                S_HROW: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt != 6'd0)
                        r_osum[osel] <= sat24(26'(r_osum[osel])
                                              + 26'($signed(r_who_rd)));
                    if (r_cnt == 6'd16) begin
                        if (r_idx[4:0] == 5'd31) begin
                            r_state <= S_O_RD; r_idx <= '0;
                        end else begin
                            r_state <= S_H_RD; r_idx <= r_idx + 6'd1;
                        end
                    end
                end
                S_O_RD: r_state <= S_O_NU;
                S_O_NU: r_state <= S_O_WB;
                S_O_WB: begin
                    if (nu_spike) r_mask[r_idx[3:0]] <= 1'b1;
                    r_cnt <= '0;
                    if (r_idx[3:0] == 4'd15) r_state <= S_ARG;
                    else begin
                        r_state <= S_O_RD; r_idx <= r_idx + 6'd1;
                    end
                end
                S_ARG: begin
                    // count at r_cnt-1 arrives now
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd1 || (r_cnt != 6'd0 && r_cnt_rd > r_best)) begin
                        r_best     <= r_cnt_rd;
                        r_best_idx <= osel;
                    end
                    if (r_cnt == 6'd16) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_odata.predicted_class <= r_best_idx;
                        r_odata.max_spike_count <= r_best;
                        r_odata.output_spikes   <= r_mask;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for lif_spiking_network_step
// fills the weight rows in use, then runs directed and random request beats
// through several register settings while a built-in network predictor
// forecasts every step result; results are checked field by field in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import lsn_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // clock, reset and dut ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_beat    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_beat   o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_DECAY;
    logic [23:0] i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    lif_spiking_network_step dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // network predictor state, a shadow of the block's memories
    logic [15:0]        nw_decay = 16'd29491;
    logic signed [23:0] nw_thresh = 24'sd256;
    logic signed [23:0] nw_rst_lvl = 24'sd0;
    logic signed [23:0] in_pot [IN_SIZE];
    logic signed [23:0] hid_pot [HID_SIZE];
    logic signed [23:0] out_pot [OUT_SIZE];
    logic signed [23:0] hid_acc [HID_SIZE];
    int unsigned        spike_cnt [OUT_SIZE];
    logic signed [15:0] w_ih [IN_SIZE*HID_SIZE];
    logic signed [15:0] w_ho [HID_SIZE*OUT_SIZE];

    // beats waiting to be sent, step results waiting to come back
    t_in_beat  req_q [$];
    t_out_beat step_result_q [$];

    int  n_fail = 0;
    int  n_sent = 0;
    int  n_steps = 0;
    bit  beat_taken = 1'b0;
    bit  tx_idle_on = 1'b1;
    bit  tx_pause = 1'b0;
    bit  rx_idle_on = 1'b1;
    bit  rx_hold_go = 1'b0;
    int  rx_hold_cnt = 0;

    function automatic logic signed [23:0] clamp24(input longint v);
        if (v > longint'(P_MAX)) return P_MAX;
        if (v < longint'(P_MIN)) return P_MIN;
        return v[23:0];
    endfunction

    // leak, integrate and fire one membrane; returns 1 on a spike
    function automatic bit lif_fire(input logic signed [23:0] p_old, input longint cur,
                                    output logic signed [23:0] p_new);
        longint prod;
        logic signed [23:0] p;
        prod = longint'(p_old) * longint'({1'b0, nw_decay}) + 64'sd16384;
        p = clamp24((prod >>> 15) + cur);
        if (p >= nw_thresh) begin
            p_new = nw_rst_lvl;
            return 1'b1;
        end
        p_new = p;
        return 1'b0;
    endfunction

    function automatic void clear_membranes();
        foreach (in_pot[i]) in_pot[i] = '0;
        foreach (hid_pot[i]) hid_pot[i] = '0;
        foreach (out_pot[i]) out_pot[i] = '0;
        foreach (hid_acc[i]) hid_acc[i] = '0;
        foreach (spike_cnt[i]) spike_cnt[i] = 0;
    endfunction

    // apply one accepted request beat; a completed step queues its result
    function automatic void predict_request(input t_in_beat b);
        logic signed [23:0] np;
        longint             osum [OUT_SIZE];
        t_out_beat          r;
        int unsigned        best;
        logic [15:0]        mask;
        case (b.req_type)
            REQ_WEIGHT: begin
                if (b.weight_layer == 1'b0)
                    w_ih[b.src_index*HID_SIZE + b.dst_index] = b.value;
                else if (b.src_index < HID_SIZE && b.dst_index < OUT_SIZE)
                    w_ho[b.src_index*OUT_SIZE + b.dst_index] = b.value;
            end
            REQ_RESET: clear_membranes();
            REQ_INPUT: begin
                if (lif_fire(in_pot[b.src_index], longint'(b.value), np)) begin
                    for (int j = 0; j < HID_SIZE; j++)
                        hid_acc[j] = clamp24(longint'(hid_acc[j]) +
                                             longint'(w_ih[b.src_index*HID_SIZE + j]));
                end
                in_pot[b.src_index] = np;
                if (b.last_input) begin
                    foreach (osum[k]) osum[k] = 0;
                    for (int j = 0; j < HID_SIZE; j++) begin
                        if (lif_fire(hid_pot[j], longint'(hid_acc[j]), np)) begin
                            for (int k = 0; k < OUT_SIZE; k++)
                                osum[k] = clamp24(osum[k] +
                                                  longint'(w_ho[j*OUT_SIZE + k]));
                        end
                        hid_pot[j] = np;
                        hid_acc[j] = '0;
                    end
                    mask = '0;
                    for (int k = 0; k < OUT_SIZE; k++) begin
                        if (lif_fire(out_pot[k], osum[k], np)) begin
                            mask[k] = 1'b1;
                            if (spike_cnt[k] < 65535) spike_cnt[k]++;
                        end
                        out_pot[k] = np;
                    end
                    // argmax, lowest index wins a tie
                    best = spike_cnt[0];
                    r.predicted_class = '0;
                    for (int k = 1; k < OUT_SIZE; k++) begin
                        if (spike_cnt[k] > best) begin
                            best = spike_cnt[k];
                            r.predicted_class = 4'(k);
                        end
                    end
                    r.max_spike_count = 16'(best);
                    r.output_spikes = mask;
                    step_result_q.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        n_fail++;
    endtask

    // input side: beat accepted at the rising edge feeds the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_request(i_in_data);
            beat_taken = 1'b1;
            n_sent++;
        end
    end

    // driver: a new beat only once the previous one was taken
    always @(negedge i_clk) begin
        if (!i_in_valid || beat_taken) begin
            beat_taken = 1'b0;
            if (req_q.size() == 0 || tx_pause || !i_rst_n ||
                (tx_idle_on && $urandom_range(0, 99) < 30)) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_in_data <= req_q.pop_front();
            end
        end
    end

    // receiver stall: random, off, or one long hold-off counted here
    always @(negedge i_clk) begin
        if (rx_hold_go) begin
            rx_hold_go = 1'b0;
            rx_hold_cnt = 4000;
        end
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= rx_idle_on && ($urandom_range(0, 99) < 30);
        end
    end

    // monitor: compare each result beat against the oldest forecast
    always @(posedge i_clk) begin
        t_out_beat e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_steps++;
            if (step_result_q.size() == 0) begin
                flag_mismatch("result beat with nothing expected");
            end else begin
                e = step_result_q.pop_front();
                if (o_out_data.predicted_class !== e.predicted_class)
                    flag_mismatch($sformatf("predicted_class got %0d exp %0d",
                                  o_out_data.predicted_class, e.predicted_class));
                if (o_out_data.max_spike_count !== e.max_spike_count)
                    flag_mismatch($sformatf("max_spike_count got %0d exp %0d",
                                  o_out_data.max_spike_count, e.max_spike_count));
                if (o_out_data.output_spikes !== e.output_spikes)
                    flag_mismatch($sformatf("output_spikes got %h exp %h",
                                  o_out_data.output_spikes, e.output_spikes));
            end
        end
    end

    function automatic t_in_beat mk_beat(input logic [1:0] rt, input logic lay,
                                         input int src, input int dst,
                                         input int val, input logic lst);
        t_in_beat b;
        b.req_type = rt;
        b.weight_layer = lay;
        b.src_index = 6'(src);
        b.dst_index = 5'(dst);
        b.value = 16'(val);
        b.last_input = lst;
        return b;
    endfunction

    // input neurons in use: 0..7 and 56..63, their weight rows are the ones filled at start
    function automatic int in_row(input int n);
        return (n < 8) ? n : n + 48;
    endfunction

    // weights mostly small and excitatory so that spikes travel through
    function automatic int pick_weight();
        if ($urandom_range(0, 49) == 0) return $urandom_range(0, 65535);
        return int'($urandom_range(0, 260)) - 70;
    endfunction

    function automatic t_in_beat pick_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 78)
            return mk_beat(REQ_INPUT, 1'($urandom), in_row($urandom_range(0, 15)),
                           $urandom_range(0, 31),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : int'($urandom_range(0, 900)) - 300,
                           $urandom_range(0, 5) == 0);
        if (r < 87)
            return mk_beat(REQ_WEIGHT, 1'($urandom), $urandom_range(0, 63),
                           $urandom_range(0, 31), pick_weight(), 1'($urandom));
        if (r < 90)
            return mk_beat(REQ_RESET, 1'($urandom), $urandom_range(0, 63),
                           $urandom_range(0, 31), $urandom_range(0, 65535), 1'($urandom));
        if (r < 93)
            return mk_beat(2'd3, 1'($urandom), $urandom_range(0, 63),
                           $urandom_range(0, 31), $urandom_range(0, 65535), 1'($urandom));
        // full-range current, always ends a step
        return mk_beat(REQ_INPUT, 1'($urandom), in_row($urandom_range(0, 15)),
                       $urandom_range(0, 31), $urandom_range(0, 65535), 1'b1);
    endfunction

    // wait until every beat is sent and every result has come back
    task automatic drain_quiet();
        wait (req_q.size() == 0 && !i_in_valid && step_result_q.size() == 0);
        // a request without a result may still be at work
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_DECAY:  nw_decay = val[15:0];
            CFG_THRESH: nw_thresh = val;
            CFG_RESET:  nw_rst_lvl = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // register settings per random phase: decay, threshold, reset level
    logic [23:0] ph_decay [5] = '{24'd29491, 24'd32768, 24'd0, 24'd65535, 24'd16384};
    logic [23:0] ph_thresh [5] = '{24'd256, 24'h7FFFFF, 24'h800000, 24'd900, 24'h000001};
    logic [23:0] ph_rst [5] = '{24'd0, 24'h800000, 24'h7FFFFF, 24'hFFFF00, 24'd100};

    initial begin
        clear_membranes();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill the weight rows in use before any neuron can read them
        for (int s = 0; s < 16; s++)
            for (int d = 0; d < HID_SIZE; d++)
                req_q.push_back(mk_beat(REQ_WEIGHT, 1'b0, in_row(s), d, pick_weight(), 1'b0));
        for (int s = 0; s < HID_SIZE; s++)
            for (int d = 0; d < OUT_SIZE; d++)
                req_q.push_back(mk_beat(REQ_WEIGHT, 1'b1, s, d, pick_weight(), 1'b0));

        // directed: field extremes, every request type, ignored cases
        req_q.push_back(mk_beat(REQ_INPUT, 1'b0, 0, 0, 32767, 1'b0));
        req_q.push_back(mk_beat(REQ_INPUT, 1'b1, 63, 31, 32767, 1'b1));
        req_q.push_back(mk_beat(REQ_INPUT, 1'b0, 63, 0, -32768, 1'b1));
        req_q.push_back(mk_beat(REQ_INPUT, 1'b0, 5, 0, 0, 1'b1));
        req_q.push_back(mk_beat(REQ_INPUT, 1'b0, 5, 0, 255, 1'b0));
        req_q.push_back(mk_beat(REQ_INPUT, 1'b0, 5, 0, 256, 1'b1));
        req_q.push_back(mk_beat(REQ_WEIGHT, 1'b1, 40, 20, -32768, 1'b1));
        req_q.push_back(mk_beat(REQ_WEIGHT, 1'b1, 31, 15, 32767, 1'b1));
        req_q.push_back(mk_beat(REQ_WEIGHT, 1'b0, 63, 31, 32767, 1'b0));
        req_q.push_back(mk_beat(2'd3, 1'b1, 63, 31, -1, 1'b1));
        req_q.push_back(mk_beat(REQ_INPUT, 1'b0, 63, 0, 32767, 1'b1));
        req_q.push_back(mk_beat(REQ_RESET, 1'b1, 63, 31, -1, 1'b1));
        req_q.push_back(mk_beat(REQ_INPUT, 1'b0, 63, 0, 32767, 1'b1));
        for (int n = 0; n < 6; n++)
            req_q.push_back(mk_beat(REQ_INPUT, 1'b0, in_row(n * 3), 0, 32767, n == 5));
        drain_quiet();

        // random phases, each under a new register setting
        for (int ph = 0; ph < 5; ph++) begin
            set_register(CFG_DECAY, ph_decay[ph]);
            set_register(CFG_THRESH, ph_thresh[ph]);
            set_register(CFG_RESET, ph_rst[ph]);
            tx_idle_on = (ph != 1);
            rx_idle_on = (ph != 1);
            for (int n = 0; n < 90; n++) req_q.push_back(pick_request());
            if (ph == 2) begin
                // long receiver hold-off while beats keep coming
                wait (step_result_q.size() != 0);
                rx_hold_go = 1'b1;
            end
            if (ph == 3) begin
                // sender waits until the block has caught up
                wait (req_q.size() < 45);
                tx_pause = 1'b1;
                wait (step_result_q.size() == 0);
                repeat (50) @(posedge i_clk);
                tx_pause = 1'b0;
            end
            drain_quiet();
        end

        repeat (800) @(posedge i_clk);
        if (step_result_q.size() != 0)
            flag_mismatch($sformatf("%0d step results never came", step_result_q.size()));
        $display("covered %0d request beats, %0d step results, 5 register settings",
                 n_sent, n_steps);
        $display("including saturation, decay 0 and above 1.0, reset and ignored requests");
        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/lsn_pkg.sv
rtl/lsn_neuron.sv
rtl/lif_spiking_network_step.sv
tb/tb.sv
